// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- design/bmp_pkg.sv -----
// Types, constants and pixel decode helpers for the BMP to mono bitmap converter.
`default_nettype none

package bmp_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned DimW     = 13;
  localparam int unsigned DepthW   = 6;
  localparam int unsigned RowW     = 12;
  localparam int unsigned DByteW   = 9;
  localparam int unsigned BirW     = 15;
  localparam int unsigned PixW     = 19;
  localparam int unsigned CntW     = 4;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegDepth  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DepthOne   = 3'd0,
    DepthTwo   = 3'd1,
    DepthFour  = 3'd2,
    DepthEight = 3'd3,
    DepthRgb   = 3'd4,
    DepthOther = 3'd5
  } depth_e;

  typedef struct packed {
    logic [7:0]        raw;
    depth_e            depth;
    logic [2:0]        col_lo;
    logic [CntW-1:0]   n_pix;
    logic              rgb_black;
    logic              emit;
    logic [DByteW-1:0] dest_byte;
    logic [RowW-1:0]   dest_row;
    logic              last;
  } pix_work_t;

  function automatic logic pal_black(logic [7:0] b, depth_e dep, logic [2:0] pos);
    logic [1:0] f2;
    logic [3:0] f4;
    logic       res;
    f2 = 2'(b >> (3'd6 - {pos[1:0], 1'b0}));
    f4 = 4'(b >> (pos[0] ? 3'd0 : 3'd4));
    unique case (dep)
      DepthOne:   res = b[3'd7 - pos];
      DepthTwo:   res = (f2 != 2'd0);
      DepthFour:  res = (f4 != 4'd0);
      DepthEight: res = (b != 8'd0);
      default:    res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- design/bmp_if.sv -----
// Valid/ready channel interfaces: raw byte input, packed output, register writes.
`default_nettype none

interface bmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface bmp_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  mono_byte;
  logic [bmp_pkg::RowW-1:0]    dest_row;
  logic [bmp_pkg::DByteW-1:0]  dest_byte;
  logic                        last_of_image;
  modport source (output valid, output mono_byte, output dest_row, output dest_byte,
                  output last_of_image, input ready);
  modport sink (input valid, input mono_byte, input dest_row, input dest_byte,
                input last_of_image, output ready);
endinterface

interface bmp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmp_pkg::CfgIdxW-1:0]   index;
  logic [bmp_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/bmp_front.sv -----
// Front end: config registers, row/pixel counters, pad drop and per-byte classification.
`default_nettype none

module bmp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  bmp_in_if.sink             raw_i,
  bmp_cfg_if.sink            cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output bmp_pkg::pix_work_t q_data_o,
  output logic               restart_o
);
  import bmp_pkg::*;

  logic [DimW-1:0]   width_q, height_q;
  logic [DepthW-1:0] depth_q;
  logic [PixW-1:0]   prod_q;
  logic [BirW-1:0]   line_q;
  logic [1:0]        settle_q;

  logic [BirW-1:0]   bir_q;
  logic [RowW-1:0]   frow_q;
  logic [DimW-1:0]   col_q;
  logic [PixW-1:0]   pend_q;
  logic [7:0]        cand_q;
  logic [1:0]        bip_q;

  logic [DimW-1:0]   w_eff, h_eff, rem, col_next, emit_col;
  logic [DepthW-1:0] d_eff;
  depth_e            dep;
  logic              rgb, cfg_hit, accept, col_lt_w, at_end, emit, row_done;
  logic [PixW-1:0]   byte_end;
  logic [PixW-1:0]   pix_end [8];
  logic [7:0]        ok;
  logic [CntW-1:0]   n;
  logic [7:0]        cand_upd;
  logic [1:0]        bip_upd;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit = cfg_i.valid &&
                   (cfg_i.index == RegWidth || cfg_i.index == RegHeight ||
                    cfg_i.index == RegDepth);

  always_comb begin
    if (width_q == '0) begin
      w_eff = DimW'(1);
    end else if (width_q > DimW'(MaxWidth)) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DimW'(1);
    end else if (height_q > DimW'(MaxHeight)) begin
      h_eff = DimW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
    d_eff = (depth_q == '0) ? DepthW'(1) : depth_q;
  end

  always_comb begin
    unique case (d_eff)
      6'd1:        dep = DepthOne;
      6'd2:        dep = DepthTwo;
      6'd4:        dep = DepthFour;
      6'd8:        dep = DepthEight;
      6'd24, 6'd32: dep = DepthRgb;
      default:     dep = DepthOther;
    endcase
  end
  assign rgb = (dep == DepthRgb);

  assign raw_i.ready = !q_full_i && (settle_q == 2'd0);
  assign accept      = raw_i.valid && raw_i.ready;

  assign byte_end = {1'b0, bir_q + BirW'(1), 3'b000};
  assign rem      = w_eff - col_q;
  assign col_lt_w = (col_q < w_eff);

  always_comb begin
    n = '0;
    for (int k = 0; k < 8; k++) begin
      pix_end[k] = pend_q + PixW'(k + 1) * PixW'(d_eff);
      ok[k]      = (pix_end[k] <= byte_end) && (DimW'(k) < rem);
      n          = n + CntW'(ok[k]);
    end
  end

  assign cand_upd = (rgb && col_lt_w && bip_q != 2'd3) ? (cand_q & raw_i.raw_byte) : cand_q;
  assign bip_upd  = (rgb && col_lt_w) ? bip_q + 2'd1 : bip_q;

  assign col_next = col_q + DimW'(n);
  assign at_end   = (n != '0) && (col_next == w_eff);
  assign emit     = (n != '0) && (at_end || ({1'b0, col_q[2:0]} + n >= CntW'(8)));
  assign emit_col = at_end ? (w_eff - DimW'(1)) : (col_q | DimW'(7));
  assign row_done = ({1'b0, bir_q} + (BirW + 1)'(1) >= {1'b0, line_q});

  assign q_push_o = accept && (n != '0);
  assign restart_o = cfg_hit;

  always_comb begin
    q_data_o.raw       = raw_i.raw_byte;
    q_data_o.depth     = dep;
    q_data_o.col_lo    = col_q[2:0];
    q_data_o.n_pix     = n;
    q_data_o.rgb_black = (cand_upd != 8'hFF);
    q_data_o.emit      = emit;
    q_data_o.dest_byte = emit_col[DByteW+2:3];
    q_data_o.dest_row  = RowW'(h_eff - DimW'(1) - {1'b0, frow_q});
    q_data_o.last      = at_end && ({1'b0, frow_q} == h_eff - DimW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      depth_q  <= DepthW'(1);
      settle_q <= 2'd0;
    end else if (cfg_hit) begin
      settle_q <= 2'd2;
      unique case (cfg_i.index)
        RegWidth:  width_q  <= cfg_i.data;
        RegHeight: height_q <= cfg_i.data;
        RegDepth:  depth_q  <= cfg_i.data[DepthW-1:0];
        default:   settle_q <= 2'd2;
      endcase
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= PixW'(1);
      line_q <= BirW'(4);
    end else begin
      prod_q <= PixW'(d_eff) * PixW'(w_eff);
      line_q <= {13'((prod_q - PixW'(1)) >> 5) + 13'd1, 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bir_q  <= '0;
      frow_q <= '0;
      col_q  <= '0;
      pend_q <= '0;
      cand_q <= 8'hFF;
      bip_q  <= '0;
    end else if (cfg_hit) begin
      bir_q  <= '0;
      frow_q <= '0;
      col_q  <= '0;
      pend_q <= '0;
      cand_q <= 8'hFF;
      bip_q  <= '0;
    end else if (accept) begin
      if (row_done) begin
        bir_q  <= '0;
        col_q  <= '0;
        pend_q <= '0;
        cand_q <= 8'hFF;
        bip_q  <= '0;
        frow_q <= ({1'b0, frow_q} + DimW'(1) >= h_eff) ? '0 : frow_q + RowW'(1);
      end else begin
        bir_q  <= bir_q + BirW'(1);
        col_q  <= col_next;
        pend_q <= pend_q + PixW'(n) * PixW'(d_eff);
        cand_q <= (rgb && n != '0) ? 8'hFF : cand_upd;
        bip_q  <= (rgb && n != '0) ? 2'd0 : bip_upd;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/bmp_queue.sv -----
// Two-entry queue of classified pixel bytes between front and back end.
`default_nettype none

module bmp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bmp_pkg::pix_work_t data_i,
  output logic               full_o,
  output logic               valid_o,
  output bmp_pkg::pix_work_t data_o,
  input  logic               pop_i
);
  import bmp_pkg::*;

  pix_work_t  slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- design/bmp_back.sv -----
// Back end: decode pixels, pack bits MSB first and hold the output register.
`default_nettype none

module bmp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  bmp_pkg::pix_work_t q_data_i,
  output logic               q_pop_o,
  input  logic               restart_i,
  bmp_out_if.source          mono_o
);
  import bmp_pkg::*;

  logic [7:0]        acc_q;
  logic              out_valid_q;
  logic [7:0]        mono_q;
  logic [RowW-1:0]   row_q;
  logic [DByteW-1:0] byte_q;
  logic              last_q;

  logic              take;
  logic [7:0]        newbits, merged;
  logic [2:0]        pos [8];
  logic              blk [8];

  assign take    = q_valid_i && (!out_valid_q || mono_o.ready);
  assign q_pop_o = take;

  always_comb begin
    newbits = '0;
    for (int k = 0; k < 8; k++) begin
      pos[k] = q_data_i.col_lo + 3'(k);
      blk[k] = (q_data_i.depth == DepthRgb) ? q_data_i.rgb_black
                                            : pal_black(q_data_i.raw, q_data_i.depth, pos[k]);
      if (CntW'(k) < q_data_i.n_pix && blk[k]) begin
        newbits[3'd7 - pos[k]] = 1'b1;
      end
    end
  end
  assign merged = acc_q | newbits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        acc_q <= '0;
      end else if (take) begin
        acc_q <= q_data_i.emit ? 8'd0 : merged;
      end
      if (take && q_data_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (mono_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && q_data_i.emit) begin
      mono_q <= merged;
      row_q  <= q_data_i.dest_row;
      byte_q <= q_data_i.dest_byte;
      last_q <= q_data_i.last;
    end
  end

  assign mono_o.valid         = out_valid_q;
  assign mono_o.mono_byte     = mono_q;
  assign mono_o.dest_row      = row_q;
  assign mono_o.dest_byte     = byte_q;
  assign mono_o.last_of_image = last_q;

endmodule

`default_nettype wire

// ----- design/bmp_raster_to_mono_bitmap.sv -----
// Top level: converts a BMP pixel array byte stream into packed 1 bpp bytes.
// Throughput: one raw byte per cycle unless queue full; front end drops pad bytes.
// A completed result passes through a queue slot, then the output register.
// Register write: input is held off while the row length is recomputed.
// Reset: async, clears counters and queue; width, height and depth return to 1.
`default_nettype none
`include "assert_macros.svh"

module bmp_raster_to_mono_bitmap (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmp_in_if.sink     raw_i,
  bmp_out_if.source  mono_o,
  bmp_cfg_if.sink    cfg_i
);
  import bmp_pkg::*;

  logic      q_push, q_full, q_valid, q_pop, restart;
  pix_work_t q_wdata, q_rdata;

  bmp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .raw_i     (raw_i),
    .cfg_i     (cfg_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata),
    .restart_o (restart)
  );

  bmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  bmp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .restart_i (restart),
    .mono_o    (mono_o)
  );

  `ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, q_push && q_full)
  `ASSERT_NEVER(a_queue_underflow, clk_i, rst_ni, q_pop && !q_valid)
  `ASSERT_NEVER(a_last_row, clk_i, rst_ni, mono_o.valid && mono_o.last_of_image && |mono_o.dest_row)
  `ASSERT_PROP(a_cfg_holdoff, clk_i, rst_ni, restart |=> !(raw_i.valid && raw_i.ready))

endmodule

`default_nettype wire

// ----- tb/sv/bmp_raster_to_mono_bitmap_tb.sv -----
// Self-checking testbench for the BMP pixel array to packed 1 bpp converter.
`timescale 1ns / 1ps

module bmp_raster_to_mono_bitmap_tb;
  import bmp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomItems = 1900;

  typedef struct packed {
    logic [7:0]        mono;
    logic [RowW-1:0]   row;
    logic [DByteW-1:0] byte_idx;
    logic              last;
  } mono_res_t;

  logic clk_i;
  logic rst_ni;

  bmp_in_if  raw_if ();
  bmp_out_if mono_if ();
  bmp_cfg_if cfg_if ();

  bmp_raster_to_mono_bitmap dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .raw_i  (raw_if),
    .mono_o (mono_if),
    .cfg_i  (cfg_if)
  );

  // Converter state mirrored by the predictor.
  int unsigned cfg_width;
  int unsigned cfg_height;
  int unsigned cfg_depth;
  int unsigned row_pos;
  int unsigned src_row;
  int unsigned pix_col;
  int unsigned pix_byte;
  logic [7:0]  color_acc;
  logic [7:0]  pack_acc;

  logic [7:0]  pending_bytes[$];
  logic [7:0]  dir_bytes[$];
  mono_res_t   mono_expected[$];
  mono_res_t   got_res;
  mono_res_t   exp_res;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_err;
  int unsigned n_rand;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned snk_next;
  int unsigned quiet;
  bit          src_burst;
  bit          snk_burst;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    return (v == 0) ? 1 : ((v > lim) ? lim : v);
  endfunction

  function automatic int unsigned row_len(input int unsigned w_reg, input int unsigned d_reg);
    int unsigned w;
    int unsigned d;
    w = clamp_dim(w_reg, MaxWidth);
    d = (d_reg == 0) ? 1 : d_reg;
    return ((d * w - 1) / 32 + 1) * 4;
  endfunction

  function automatic void restart_image();
    row_pos   = 0;
    src_row   = 0;
    pix_col   = 0;
    pix_byte  = 0;
    color_acc = 8'hFF;
    pack_acc  = 8'h00;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    bit hit;
    hit = 1'b1;
    case (idx)
      RegWidth:  cfg_width = 32'(val);
      RegHeight: cfg_height = 32'(val);
      RegDepth:  cfg_depth = 32'(val[DepthW-1:0]);
      default:   hit = 1'b0;
    endcase
    if (hit) restart_image();
  endfunction

  function automatic void convert_byte(input logic [7:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned d;
    int unsigned line_len;
    int unsigned col;
    int unsigned sh;
    int unsigned mask;
    int unsigned k;
    bit          rgb;
    bit          black;
    bit          stop;
    mono_res_t   res;
    w = clamp_dim(cfg_width, MaxWidth);
    h = clamp_dim(cfg_height, MaxHeight);
    d = (cfg_depth == 0) ? 1 : cfg_depth;
    line_len = row_len(cfg_width, cfg_depth);
    rgb = (d == 24 || d == 32);
    if (rgb && pix_col < w) begin
      if (pix_byte < 3) color_acc = color_acc & b;
      pix_byte = (pix_byte + 1) % 4;
    end
    k = 0;
    stop = 1'b0;
    while (k < 8 && !stop) begin
      col = pix_col;
      if (col >= w || (col + 1) * d > 8 * (row_pos + 1)) begin
        stop = 1'b1;
      end else begin
        black = 1'b0;
        case (d)
          1, 2, 4, 8: begin
            sh = 8 - d - ((col * d) & 7);
            mask = (1 << d) - 1;
            black = ((32'(b) >> sh) & mask) != 0;
          end
          24, 32: begin
            black = (color_acc != 8'hFF);
            color_acc = 8'hFF;
            pix_byte = 0;
          end
          default: black = 1'b0;
        endcase
        if (black) pack_acc[7 - (col & 7)] = 1'b1;
        pix_col = col + 1;
        if ((col & 7) == 7 || col == w - 1) begin
          res.mono = pack_acc;
          res.row = (src_row < h) ? RowW'(h - 1 - src_row) : '0;
          res.byte_idx = DByteW'(col >> 3);
          res.last = (src_row == h - 1 && col == w - 1);
          mono_expected.push_back(res);
          pack_acc = 8'h00;
        end
      end
      k++;
    end
    if (row_pos + 1 >= line_len) begin
      row_pos   = 0;
      pix_col   = 0;
      pack_acc  = 8'h00;
      color_acc = 8'hFF;
      pix_byte  = 0;
      src_row   = (src_row + 1 >= h) ? 0 : src_row + 1;
    end else begin
      row_pos++;
    end
  endfunction

  function automatic int unsigned draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 8'hFF;
    if (sel < 6) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    n_queued++;
  endtask

  // Hold until every request is taken and every result is back, then settle.
  task automatic drain();
    while (n_accepted != n_queued || mono_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg(idx, val);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_dir();
    foreach (dir_bytes[i]) queue_byte(dir_bytes[i]);
  endtask

  task automatic feed_random(input int unsigned n, input bit split);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (split && i == n / 2) drain();
      queue_byte(pick_byte());
    end
  endtask

  task automatic random_phase();
    int unsigned depths[6];
    int unsigned w;
    int unsigned h;
    int unsigned d;
    int unsigned line_len;
    int unsigned img;
    int unsigned n;
    depths = '{1, 2, 4, 8, 24, 32};
    d = ($urandom_range(0, 9) < 8) ? depths[$urandom_range(0, 5)] : $urandom_range(0, 63);
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 3))
          0:       w = 0;
          1:       w = MaxWidth;
          2:       w = 8191;
          default: w = $urandom_range(MaxWidth + 1, 8191);
        endcase
      end
      1, 2, 3: w = $urandom_range(41, 300);
      default: w = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 15))
      0: begin
        case ($urandom_range(0, 3))
          0:       h = 0;
          1:       h = MaxHeight;
          2:       h = 8191;
          default: h = $urandom_range(5, 8191);
        endcase
      end
      1, 2:    h = $urandom_range(5, 20);
      default: h = $urandom_range(1, 4);
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(RegWidth, CfgDataW'(w));
    if ($urandom_range(0, 9) == 0) write_reg(RegUnused, CfgDataW'($urandom));
    if ($urandom_range(0, 3) != 0) write_reg(RegHeight, CfgDataW'(h));
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(RegDepth, {7'($urandom), 6'(d)});
      else
        write_reg(RegDepth, CfgDataW'(d));
    end
    line_len = row_len(cfg_width, cfg_depth);
    img = line_len * clamp_dim(cfg_height, MaxHeight);
    if (img <= 240)
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, img) : img * $urandom_range(1, 2);
    else
      n = $urandom_range(1, (line_len < 120) ? 2 * line_len : 240);
    src_burst = ($urandom_range(0, 3) == 0);
    snk_burst = ($urandom_range(0, 3) == 0);
    feed_random(n, $urandom_range(0, 5) == 0);
    n_rand += n;
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Request driver: one byte per request, random pause after each unless in burst mode.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      raw_if.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (raw_if.valid && raw_if.ready) begin
        convert_byte(raw_if.raw_byte);
        n_accepted++;
      end
      if (!raw_if.valid || raw_if.ready) begin
        if (src_gap != 0) begin
          raw_if.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          raw_if.valid <= 1'b1;
          raw_if.raw_byte <= pending_bytes.pop_front();
          src_gap <= draw_gap(src_burst);
        end else begin
          raw_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest predicted byte, stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mono_if.ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (mono_if.valid && mono_if.ready) begin
        got_res.mono     = mono_if.mono_byte;
        got_res.row      = mono_if.dest_row;
        got_res.byte_idx = mono_if.dest_byte;
        got_res.last     = mono_if.last_of_image;
        if (mono_expected.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result: mono %h row %0d byte %0d last %0b",
                     got_res.mono, got_res.row, got_res.byte_idx, got_res.last);
        end else begin
          exp_res = mono_expected.pop_front();
          if (got_res !== exp_res) begin
            n_err++;
            if (n_err <= 10)
              $display(
                "mismatch: exp %h row %0d byte %0d last %0b, got %h row %0d byte %0d last %0b",
                exp_res.mono, exp_res.row, exp_res.byte_idx, exp_res.last,
                got_res.mono, got_res.row, got_res.byte_idx, got_res.last);
          end
        end
        snk_next = draw_gap(snk_burst);
      end else begin
        snk_next = snk_gap;
      end
      if (snk_next != 0) begin
        mono_if.ready <= 1'b0;
        snk_gap <= snk_next - 1;
      end else begin
        mono_if.ready <= 1'b1;
        snk_gap <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (raw_if.valid && raw_if.ready) || (mono_if.valid && mono_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = RegWidth;
    cfg_if.data = '0;
    n_queued = 0;
    n_rand = 0;
    src_burst = 1'b0;
    snk_burst = 1'b0;
    cfg_width = 1;
    cfg_height = 1;
    cfg_depth = 1;
    restart_image();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry; the fifth byte starts the next image.
    dir_bytes = {8'h80, 8'h00, 8'h00, 8'h00, 8'h7F};
    send_dir();
    drain();

    // 32 bpp, alpha ignored, one black and one white pixel.
    write_reg(RegDepth, CfgDataW'(32));
    write_reg(RegWidth, CfgDataW'(2));
    write_reg(RegHeight, CfgDataW'(1));
    dir_bytes = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFE, 8'hFF, 8'hFF};
    send_dir();
    drain();

    // Depth zero, width zero, height past the limit.
    write_reg(RegDepth, 13'h1FC0);
    write_reg(RegWidth, 13'h0000);
    write_reg(RegHeight, 13'h1FFF);
    dir_bytes = {8'hFF, 8'h00, 8'hAA, 8'h55};
    send_dir();
    drain();

    // 4 bpp, partial last byte, write to an unused index mid row.
    write_reg(RegDepth, CfgDataW'(4));
    write_reg(RegWidth, CfgDataW'(3));
    write_reg(RegHeight, CfgDataW'(2));
    dir_bytes = {8'hF0, 8'h01};
    send_dir();
    drain();
    write_reg(RegUnused, 13'h1FFF);
    dir_bytes = {8'h00, 8'h00, 8'h0F, 8'h10, 8'h00, 8'h00};
    send_dir();
    drain();

    // Widest row at 1 bpp.
    write_reg(RegWidth, CfgDataW'(MaxWidth));
    write_reg(RegHeight, CfgDataW'(1));
    write_reg(RegDepth, CfgDataW'(1));
    feed_random(512, 1'b0);
    n_rand = 512;
    drain();

    while (n_rand < RandomItems) random_phase();
    drain();

    if (n_err == 0 && mono_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/bmp_pkg.sv
design/bmp_if.sv
design/bmp_front.sv
design/bmp_queue.sv
design/bmp_back.sv
design/bmp_raster_to_mono_bitmap.sv
tb/sv/bmp_raster_to_mono_bitmap_tb.sv
